/* rtl/core/clock_divider_search_assert.svh */
// Assertion macros shared by the clock divider search RTL.
// Expects clk and rst in the scope of every use.
`ifndef CLOCK_DIVIDER_SEARCH_ASSERT_SVH
`define CLOCK_DIVIDER_SEARCH_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define CLKDS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define CLKDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/clkds_pkg.sv */
// Package for the clock divider search: widths, register indexes and the
// command/status words between controller and datapath. No dependencies.
`default_nettype none

package clkds_pkg;

  localparam int FreqW          = 32;
  localparam int BaseW          = 31;
  localparam int ScaleW         = 5;
  localparam int MaskW          = 17;
  localparam int ExpW           = 5;
  localparam int DivW           = 16;
  localparam int MaxPrescaleExp = 16;
  localparam int MaxScale       = 16;
  localparam int CntW           = $clog2(FreqW);
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 31;

  localparam logic [CfgIdxW-1:0] RegBaseFreq     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegScaleBits    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPrescaleMask = 2'd2;

  localparam logic [BaseW-1:0]  BaseFreqRst     = 31'd16000000;
  localparam logic [ScaleW-1:0] ScaleBitsRst    = 5'd16;
  localparam logic [MaskW-1:0]  PrescaleMaskRst = 17'd1353;

  typedef struct packed {
    logic load;
    logic next_exp;
    logic div_init;
    logic div_step;
    logic clear_result;
    logic set_result;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_in;
    logic exp_end;
    logic exp_ok;
    logic div_last;
    logic div_fits;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/clkds_ctrl.sv */
// Controller of the clock divider search: walks the prescaler exponents and
// sequences the iterative division. Depends on clkds_pkg and the assert header.
`default_nettype none

`include "clock_divider_search_assert.svh"

module clkds_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done,
  output clkds_pkg::dp_cmd_t      cmd,
  input  wire clkds_pkg::dp_stat_t stat
);
  import clkds_pkg::*;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StCheck  = 5'b00010,
    StDivide = 5'b00100,
    StJudge  = 5'b01000,
    StDone   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      StIdle: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = StCheck;
        end
      end
      StCheck: begin
        priority if (stat.zero_in || stat.exp_end) begin
          cmd.clear_result = 1'b1;
          state_next       = StDone;
        end else if (stat.exp_ok) begin
          cmd.div_init = 1'b1;
          state_next   = StDivide;
        end else begin
          cmd.next_exp = 1'b1;
        end
      end
      StDivide: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = StJudge;
        end
      end
      StJudge: begin
        if (stat.div_fits) begin
          cmd.set_result = 1'b1;
          state_next     = StDone;
        end else begin
          cmd.next_exp = 1'b1;
          state_next   = StCheck;
        end
      end
      StDone: begin
        state_next = StIdle;
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  assign busy = (state != StIdle);
  assign done = (state == StDone);

  `CLKDS_ASSERT_NEXT(a_done_single, done, !done, "done strobe held longer than one cycle")
  `CLKDS_ASSERT_NEXT(a_zero_fails, (state == StCheck) && stat.zero_in,
                     done, "zero input did not finish at once")

endmodule

`default_nettype wire

/* rtl/core/clkds_dp.sv */
// Datapath of the clock divider search: configuration registers, exponent
// counter, prescaled clock rounding, radix-2 divider and result registers.
// Depends on clkds_pkg and the assert header.
`default_nettype none

`include "clock_divider_search_assert.svh"

module clkds_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [clkds_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [clkds_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic [clkds_pkg::FreqW-1:0]     freq_hz,
  input  wire clkds_pkg::dp_cmd_t              cmd,
  output clkds_pkg::dp_stat_t                  stat,
  output logic                                 found,
  output logic [clkds_pkg::ExpW-1:0]           prescale_exp,
  output logic [clkds_pkg::DivW-1:0]           divider_minus_one
);
  import clkds_pkg::*;

  logic [BaseW-1:0]  base_freq_hz;
  logic [ScaleW-1:0] scale_bits;
  logic [MaskW-1:0]  prescale_mask;

  logic [FreqW-1:0]  freq;
  logic [ExpW-1:0]   exp;
  logic [FreqW-1:0]  rem;
  logic [FreqW-1:0]  quo;
  logic [CntW-1:0]   cnt;

  logic [FreqW-1:0]  shifted;
  logic [FreqW-1:0]  shifted_inc;
  logic [BaseW-1:0]  scaled;
  logic [FreqW:0]    trial;
  logic [FreqW:0]    diff;
  logic              ge;
  logic [FreqW:0]    quo_inc;
  logic [FreqW-1:0]  div_round;
  logic [ScaleW-1:0] width;
  logic [DivW:0]     max_div;
  logic [MaskW-1:0]  mask_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_freq_hz  <= BaseFreqRst;
      scale_bits    <= ScaleBitsRst;
      prescale_mask <= PrescaleMaskRst;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegBaseFreq:     base_freq_hz  <= cfg_data[BaseW-1:0];
        RegScaleBits:    scale_bits    <= cfg_data[ScaleW-1:0];
        RegPrescaleMask: prescale_mask <= cfg_data[MaskW-1:0];
        default: ;
      endcase
    end
  end

  // round(base / 2^exp)
  assign shifted     = {base_freq_hz, 1'b0} >> exp;
  assign shifted_inc = shifted + FreqW'(1);
  assign scaled      = shifted_inc[FreqW-1:1];
  assign mask_shift  = prescale_mask >> exp;

  // one restoring division step
  assign trial = {rem, quo[FreqW-1]};
  assign diff  = trial - {1'b0, freq};
  assign ge    = !diff[FreqW];

  assign quo_inc   = {1'b0, quo} + (FreqW+1)'(1);
  assign div_round = quo_inc[FreqW:1];
  assign width     = (scale_bits > ScaleW'(MaxScale)) ? ScaleW'(MaxScale) : scale_bits;
  assign max_div   = (DivW+1)'(1) << width;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq <= freq_hz;
      exp  <= '0;
    end else if (cmd.next_exp) begin
      exp <= exp + ExpW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo <= {scaled, 1'b0};
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[FreqW-2:0], ge};
      rem <= ge ? diff[FreqW-1:0] : trial[FreqW-1:0];
      cnt <= cnt + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_result) begin
      found             <= 1'b0;
      prescale_exp      <= '0;
      divider_minus_one <= '0;
    end else if (cmd.set_result) begin
      found             <= 1'b1;
      prescale_exp      <= exp;
      divider_minus_one <= div_round[DivW-1:0] - DivW'(1);
    end
  end

  always_comb begin
    stat.zero_in  = (freq == '0) || (base_freq_hz == '0);
    stat.exp_end  = (exp > ExpW'(MaxPrescaleExp));
    stat.exp_ok   = mask_shift[0] && (scaled != '0);
    stat.div_last = (cnt == CntW'(FreqW - 1));
    stat.div_fits = (div_round != '0) && (div_round <= FreqW'(max_div));
  end

  `CLKDS_ASSERT_SAME(a_rem_below_freq, cmd.div_step, rem < freq,
                     "division remainder reached the divisor")
  `CLKDS_ASSERT_SAME(a_miss_is_zero, !found,
                     (prescale_exp == '0) && (divider_minus_one == '0),
                     "result fields not zero without a match")

endmodule

`default_nettype wire

/* rtl/core/clock_divider_search.sv */
// Top level of the clock divider search: controller, datapath and the
// configuration write port. Depends on clkds_pkg, clkds_ctrl and clkds_dp.
//
// A word on freq_hz is taken when start is high and busy is low. The block
// then tries the enabled prescaler exponents from 0 up to 16; each enabled
// exponent with a nonzero prescaled clock gets a check, a radix-2 division
// of twice the prescaled clock by freq_hz and a judge step, and each
// disabled exponent gets only a check. The single shared divider serves
// one word at a time: no new word is taken until the search is done. The
// result appears on found, prescale_exp and divider_minus_one while done is
// high for exactly one cycle; the receiver cannot stall, so it must take
// the word in that cycle. Configuration writes are always ready and must
// only be issued while busy is low.
`default_nettype none

module clock_divider_search (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [clkds_pkg::FreqW-1:0]    freq_hz,
  output logic                                done,
  output logic                                found,
  output logic [clkds_pkg::ExpW-1:0]          prescale_exp,
  output logic [clkds_pkg::DivW-1:0]          divider_minus_one,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [clkds_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [clkds_pkg::CfgDataW-1:0] cfg_data
);
  import clkds_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  clkds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  clkds_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .freq_hz           (freq_hz),
    .cmd               (cmd),
    .stat              (stat),
    .found             (found),
    .prescale_exp      (prescale_exp),
    .divider_minus_one (divider_minus_one)
  );

endmodule

`default_nettype wire
